FILE: design/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    // Window storage depth and sample width.
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;

    // Index into the window and count of samples held (count reaches MAX_WINDOW).
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // Width of the window size register word.
    localparam int CFG_W = 7;

    // Window size after reset.
    localparam int RESET_WINDOW = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;

    // Per-item control broadcast to every sorting cell.
    typedef struct packed {
        logic    update;     // a word is accepted this cycle
        logic    full;       // the window was full before this word
        cnt_t    kept;       // cells that stay valid after the leaving sample is dropped
        sample_t leaving;    // sample that leaves the window when full
        sample_t incoming;   // sample that enters the window
    } cell_ctrl_t;

endpackage

FILE: design/swm_ram.sv
`timescale 1ns / 1ps

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell (
    input  logic                clk,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  swm_pkg::cnt_t       idx,
    input  swm_pkg::sample_t    right_val,
    input  swm_pkg::sample_t    left_c,
    input  logic                left_gt,
    output swm_pkg::sample_t    val,
    output swm_pkg::sample_t    c,
    output logic                gt
);
    import swm_pkg::*;

    sample_t val_reg;
    sample_t val_next;

    assign val = val_reg;

    // Close the gap left by the leaving sample: the leaving copy is the first
    // cell that is not below it, so every cell at or above it takes its right
    // neighbor's value.
    assign c = (ctrl.full && (val_reg >= ctrl.leaving)) ? right_val : val_reg;

    // Cells past the kept region count as larger than any sample.
    assign gt = (idx >= ctrl.kept) || (c > ctrl.incoming);

    // Insert: smaller cells stay, the boundary cell takes the new sample,
    // larger cells shift one place right.
    always_comb
    begin
        if (!gt)
        begin
            val_next = c;
        end
        else if ((idx == '0) || !left_gt)
        begin
            val_next = ctrl.incoming;
        end
        else
        begin
            val_next = left_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            val_reg <= val_next;
        end
    end

endmodule

FILE: design/sliding_window_median.sv
`timescale 1ns / 1ps
// Running median over the last window_size samples (1 to 64, reset value 3).
// The median of a window is registered onto median once the output register is free to take it.
// Throughput: one sample word per cycle unless stalled; all sorting cells update in one step.
// A full output register stalls sample intake until the pending median can move into it.
// Reset clears the fill count, ring pointer and handshakes; stored samples are not cleared.

module sliding_window_median (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    output logic signed [swm_pkg::SAMPLE_BITS-1:0] median,
    output logic                                 median_valid,
    input  logic                                 median_ready,
    input  logic [swm_pkg::CFG_W-1:0]            window_size,
    input  logic                                 window_size_valid,
    output logic                                 window_size_ready
);
    import swm_pkg::*;

    cnt_t       win_reg,  win_next;
    cnt_t       cnt_reg,  cnt_next;
    idx_t       ptr_reg,  ptr_next;
    logic       byp_reg,  byp_next;
    sample_t    byp_data_reg;
    logic       pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    sample_t    median_reg, median_next;

    logic       accept;
    logic       cfg_write;
    logic       full;
    logic       result;
    logic       out_free;
    idx_t       wm1;
    idx_t       mid;
    idx_t       waddr;
    sample_t    ring_rdata;
    sample_t    leaving;
    cell_ctrl_t ctrl;

    sample_t    val [MAX_WINDOW];
    sample_t    c   [MAX_WINDOW];
    logic       gt  [MAX_WINDOW];

    assign window_size_ready = 1'b1;
    assign cfg_write = window_size_valid && window_size_ready;

    // Output register is free when empty or being drained this cycle.
    assign out_free     = !out_valid_reg || median_ready;
    assign sample_ready = !pend_reg || out_free;
    assign accept       = sample_valid && sample_ready;

    assign wm1  = IDX_W'(win_reg - 1'b1);
    assign mid  = wm1 >> 1;
    assign full = (cnt_reg == win_reg);

    // While filling the pointer sits at zero, so the ring slot is the count.
    assign waddr  = full ? ptr_reg : cnt_reg[IDX_W-1:0];
    assign result = full || ((cnt_reg + 1'b1) == win_reg);

    // Window bookkeeping and the ring pointer of the oldest sample.
    always_comb
    begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (cfg_write)
        begin
            cnt_next = '0;
            ptr_next = '0;
            if (window_size == '0)
            begin
                win_next = CNT_W'(1);
            end
            else if (32'(window_size) > 32'(MAX_WINDOW))
            begin
                win_next = CNT_W'(MAX_WINDOW);
            end
            else
            begin
                win_next = CNT_W'(window_size);
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                ptr_next = (ptr_reg == wm1) ? '0 : ptr_reg + 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // The ring is read ahead at the next pointer; a same-slot write is bypassed.
    assign byp_next = accept && (waddr == ptr_next);
    assign leaving  = byp_reg ? byp_data_reg : ring_rdata;

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (sample),
        .raddr (ptr_next),
        .rdata (ring_rdata)
    );

    // Control shared by the sorting cells.
    always_comb
    begin
        ctrl.update   = accept;
        ctrl.full     = full;
        ctrl.kept     = full ? CNT_W'(wm1) : cnt_reg;
        ctrl.leaving  = leaving;
        ctrl.incoming = sample;
    end

    // Row of sorting cells, ascending from cell zero.
    for (genvar j = 0; j < MAX_WINDOW; j++)
    begin : g_cell
        sample_t right_val;
        sample_t left_c;
        logic    left_gt;

        if (j == MAX_WINDOW - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid
            assign right_val = val[j+1];
        end

        if (j == 0)
        begin : g_first
            assign left_c  = '0;
            assign left_gt = 1'b0;
        end
        else
        begin : g_rest
            assign left_c  = c[j-1];
            assign left_gt = gt[j-1];
        end

        swm_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .idx       (CNT_W'(j)),
            .right_val (right_val),
            .left_c    (left_c),
            .left_gt   (left_gt),
            .val       (val[j]),
            .c         (c[j]),
            .gt        (gt[j])
        );
    end

    // Median tap is taken from the settled cells once the pending result can move into the output register.
    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        if (out_free)
        begin
            out_valid_next = pend_reg;
            pend_next      = 1'b0;
            if (pend_reg)
            begin
                median_next = val[mid];
            end
        end
        if (accept)
        begin
            pend_next = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= CNT_W'(RESET_WINDOW);
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            byp_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            byp_reg       <= byp_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byp_data_reg <= sample;
        median_reg   <= median_next;
    end

    assign median       = median_reg;
    assign median_valid = out_valid_reg;

    // The fill count never passes the window size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= win_reg)
        else $error("fill count exceeds window size");

    // The oldest pointer stays inside the window.
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(ptr_reg) < win_reg)
        else $error("oldest pointer outside window");

    // While the window fills, the pointer rests at slot zero.
    a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != win_reg) |-> (ptr_reg == '0))
        else $error("pointer moved before window was full");

    // A word taken into a full window leaves a median pending.
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && !cfg_write) |=> pend_reg)
        else $error("full window produced no median");

    // A median blocked in front of a stalled output holds off new samples.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && out_valid_reg && !median_ready) |-> !sample_ready)
        else $error("sample taken while median blocked");

endmodule
